@@ hw/rtl/ste_pkg.sv @@
// ============================================================================
// ste_pkg
// Shared constants and types of the surface triangle extractor: default
// sizes, request modes, response status codes and the per-cell control word.
// ============================================================================
package ste_pkg;

   localparam int TABLE_DEPTH_DEF = 256;
   localparam int INDEX_BITS_DEF  = 16;

   localparam int PORT_BITS   = 16;
   localparam int MODE_BITS   = 2;
   localparam int STATUS_BITS = 3;

   // Request modes. Any mode that is neither insert nor clear acts as a drain.
   localparam logic [MODE_BITS-1:0] MODE_INSERT = 2'd0;
   localparam logic [MODE_BITS-1:0] MODE_DRAIN  = 2'd1;
   localparam logic [MODE_BITS-1:0] MODE_CLEAR  = 2'd2;

   // Response status codes.
   localparam logic [STATUS_BITS-1:0] STAT_NEW     = 3'd0;
   localparam logic [STATUS_BITS-1:0] STAT_REPEAT  = 3'd1;
   localparam logic [STATUS_BITS-1:0] STAT_FULL    = 3'd2;
   localparam logic [STATUS_BITS-1:0] STAT_SURFACE = 3'd3;
   localparam logic [STATUS_BITS-1:0] STAT_DONE    = 3'd4;
   localparam logic [STATUS_BITS-1:0] STAT_CLEARED = 3'd5;

   // Control word broadcast from the sequencer to every cell of the ring.
   typedef struct packed {
      logic rotate;   // every cell loads its upper neighbor
      logic write;    // the cell at the write position stores a new face
      logic mark;     // the cell whose key matched becomes shared
   } ste_ctrl_type;

endpackage

@@ hw/rtl/ste_cell.sv @@
// ============================================================================
// ste_cell
// One table entry: sorted key, original corners and shared mark, with a
// local key compare and a load path from the next cell of the ring.
// ============================================================================
module ste_cell #(
   parameter int TABLE_DEPTH = ste_pkg::TABLE_DEPTH_DEF,
   parameter int INDEX_BITS  = ste_pkg::INDEX_BITS_DEF,
   parameter int CELL_INDEX  = 0
) (
   input  logic                                   clock,
   input  logic                                   reset,
   input  ste_pkg::ste_ctrl_type                  ctrl,
   input  logic [$clog2(TABLE_DEPTH)-1:0]         wr_pos,
   input  logic [$clog2(TABLE_DEPTH+1)-1:0]       live_lo,
   input  logic [$clog2(TABLE_DEPTH+1)-1:0]       live_hi,
   input  logic [3*INDEX_BITS-1:0]                key_in,
   input  logic [3*INDEX_BITS-1:0]                corners_in,
   input  logic [3*INDEX_BITS-1:0]                next_key,
   input  logic [3*INDEX_BITS-1:0]                next_corners,
   input  logic                                   next_shared,
   output logic [3*INDEX_BITS-1:0]                key_out,
   output logic [3*INDEX_BITS-1:0]                corners_out,
   output logic                                   shared_out,
   output logic                                   hit_out
);
   import ste_pkg::*;

   localparam int PW   = $clog2(TABLE_DEPTH);
   localparam int CNTW = $clog2(TABLE_DEPTH + 1);
   localparam logic [PW-1:0]   MY_POS  = PW'(CELL_INDEX);
   localparam logic [CNTW-1:0] MY_SLOT = CNTW'(CELL_INDEX);

   logic [3*INDEX_BITS-1:0] key_ff, key_in_w;
   logic [3*INDEX_BITS-1:0] corners_ff, corners_in_w;
   logic                    shared_ff, shared_in;
   logic                    hit_ff, hit_in;
   logic                    live;

   // The ring position maps onto a logical entry; the live positions are
   // those below live_lo (not yet drained) and those at or above live_hi
   // (already drained, rotated round to the top of the ring).
   assign live   = (MY_SLOT < live_lo) || (MY_SLOT >= live_hi);
   assign hit_in = live && (key_ff == key_in);

   always_comb begin
      key_in_w     = key_ff;
      corners_in_w = corners_ff;
      shared_in    = shared_ff;
      if (ctrl.rotate) begin
         key_in_w     = next_key;
         corners_in_w = next_corners;
         shared_in    = next_shared;
      end else if (ctrl.write && (wr_pos == MY_POS)) begin
         key_in_w     = key_in;
         corners_in_w = corners_in;
         shared_in    = 1'b0;
      end else if (ctrl.mark && hit_ff) begin
         shared_in    = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      key_ff     <= key_in_w;
      corners_ff <= corners_in_w;
      shared_ff  <= shared_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         hit_ff <= 1'b0;
      end else begin
         hit_ff <= hit_in;
      end
   end

   assign key_out     = key_ff;
   assign corners_out = corners_ff;
   assign shared_out  = shared_ff;
   assign hit_out     = hit_ff;

endmodule

@@ hw/rtl/ste_ring.sv @@
// ============================================================================
// ste_ring
// Row of table cells closed into a ring. Cell 0 is the drain head; a
// rotation moves every entry down one place. Reports whether any live
// entry matched the broadcast key.
// ============================================================================
module ste_ring #(
   parameter int TABLE_DEPTH = ste_pkg::TABLE_DEPTH_DEF,
   parameter int INDEX_BITS  = ste_pkg::INDEX_BITS_DEF
) (
   input  logic                                   clock,
   input  logic                                   reset,
   input  ste_pkg::ste_ctrl_type                  ctrl,
   input  logic [$clog2(TABLE_DEPTH)-1:0]         wr_pos,
   input  logic [$clog2(TABLE_DEPTH+1)-1:0]       live_lo,
   input  logic [$clog2(TABLE_DEPTH+1)-1:0]       live_hi,
   input  logic [3*INDEX_BITS-1:0]                key_in,
   input  logic [3*INDEX_BITS-1:0]                corners_in,
   output logic [3*INDEX_BITS-1:0]                head_corners,
   output logic                                   head_shared,
   output logic                                   any_hit
);
   import ste_pkg::*;

   logic [3*INDEX_BITS-1:0] key_w     [TABLE_DEPTH];
   logic [3*INDEX_BITS-1:0] corners_w [TABLE_DEPTH];
   logic                    shared_w  [TABLE_DEPTH];
   logic [TABLE_DEPTH-1:0]  hit_w;

   for (genvar p = 0; p < TABLE_DEPTH; p++) begin : g_cell
      localparam int NEXT = (p + 1) % TABLE_DEPTH;
      ste_cell #(
         .TABLE_DEPTH (TABLE_DEPTH),
         .INDEX_BITS  (INDEX_BITS),
         .CELL_INDEX  (p)
      ) u_cell (
         .clock        (clock),
         .reset        (reset),
         .ctrl         (ctrl),
         .wr_pos       (wr_pos),
         .live_lo      (live_lo),
         .live_hi      (live_hi),
         .key_in       (key_in),
         .corners_in   (corners_in),
         .next_key     (key_w[NEXT]),
         .next_corners (corners_w[NEXT]),
         .next_shared  (shared_w[NEXT]),
         .key_out      (key_w[p]),
         .corners_out  (corners_w[p]),
         .shared_out   (shared_w[p]),
         .hit_out      (hit_w[p])
      );
   end

   assign head_corners = corners_w[0];
   assign head_shared  = shared_w[0];
   assign any_hit      = |hit_w;

endmodule

@@ hw/rtl/surface_triangle_extractor.sv @@
// ============================================================================
// surface_triangle_extractor
// Boundary face extraction: stores each new triangle under a sorted key,
// marks repeated keys as shared and drains the faces seen exactly once in
// order of first appearance. A clear request empties the table.
//
//   channel   direction   handshake            payload
//   req_      in          req_valid/req_stall  req_mode, req_corner_a/b/c
//   rsp_      out         rsp_valid/rsp_stall  rsp_status, rsp_out_a/b/c,
//                                              rsp_overflowed
//
// An insert steps through accept with key sort, parallel compare in every
// cell, then mark, store or drop. A drain skips each shared entry at the head,
// as the ring rotates one entry into the head cell per cycle. Reset is
// synchronous and empties the table with no clearing pass. A stalled
// response register holds the sequencer in its final step; a new request
// is taken as soon as the sequencer is idle.
// ============================================================================
module surface_triangle_extractor #(
   parameter int TABLE_DEPTH = ste_pkg::TABLE_DEPTH_DEF,
   parameter int INDEX_BITS  = ste_pkg::INDEX_BITS_DEF
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_valid,
   output logic                                 req_stall,
   input  logic [ste_pkg::MODE_BITS-1:0]        req_mode,
   input  logic [ste_pkg::PORT_BITS-1:0]        req_corner_a,
   input  logic [ste_pkg::PORT_BITS-1:0]        req_corner_b,
   input  logic [ste_pkg::PORT_BITS-1:0]        req_corner_c,
   output logic                                 rsp_valid,
   input  logic                                 rsp_stall,
   output logic [ste_pkg::STATUS_BITS-1:0]      rsp_status,
   output logic [ste_pkg::PORT_BITS-1:0]        rsp_out_a,
   output logic [ste_pkg::PORT_BITS-1:0]        rsp_out_b,
   output logic [ste_pkg::PORT_BITS-1:0]        rsp_out_c,
   output logic                                 rsp_overflowed
);
   import ste_pkg::*;

   localparam int CW   = INDEX_BITS;
   localparam int PW   = $clog2(TABLE_DEPTH);
   localparam int CNTW = $clog2(TABLE_DEPTH + 1);
   localparam logic [CNTW-1:0] DEPTH_CNT = CNTW'(TABLE_DEPTH);

   localparam logic [2:0] S_IDLE    = 3'd0;
   localparam logic [2:0] S_LOOKUP  = 3'd1;
   localparam logic [2:0] S_RESOLVE = 3'd2;
   localparam logic [2:0] S_DRAIN   = 3'd3;
   localparam logic [2:0] S_CLEAR   = 3'd4;

   logic [2:0]        state_ff, state_in;
   logic [CNTW-1:0]   count_ff, count_in;
   logic [CNTW-1:0]   cursor_ff, cursor_in;
   logic              ovf_ff, ovf_in;
   logic [3*CW-1:0]   key_ff, key_in;
   logic [3*CW-1:0]   corners_ff, corners_in;

   logic                   rsp_valid_ff, rsp_valid_in;
   logic [STATUS_BITS-1:0] rsp_status_ff, rsp_status_in;
   logic [PORT_BITS-1:0]   rsp_a_ff, rsp_a_in;
   logic [PORT_BITS-1:0]   rsp_b_ff, rsp_b_in;
   logic [PORT_BITS-1:0]   rsp_c_ff, rsp_c_in;
   logic                   rsp_ovf_ff, rsp_ovf_in;

   logic              req_xfer, out_free, emit;
   logic [CW-1:0]     ca, cb, cc;
   logic [CW-1:0]     s0a, s0b, s1b, s1c, k0, k1, k2;
   logic [CNTW-1:0]   live_lo, live_hi;
   logic [3*CW-1:0]   head_corners;
   logic              head_shared, any_hit;
   ste_ctrl_type      ctrl;

   assign req_stall = (state_ff != S_IDLE);
   assign req_xfer  = req_valid && !req_stall;
   assign out_free  = !rsp_valid_ff || !rsp_stall;

   // Corners are narrowed or widened to the index width, then sorted
   // largest first with three compare-exchange steps.
   assign ca  = CW'(req_corner_a);
   assign cb  = CW'(req_corner_b);
   assign cc  = CW'(req_corner_c);
   assign s0a = (ca < cb) ? cb : ca;
   assign s0b = (ca < cb) ? ca : cb;
   assign s1b = (s0b < cc) ? cc : s0b;
   assign s1c = (s0b < cc) ? s0b : cc;
   assign k0  = (s0a < s1b) ? s1b : s0a;
   assign k1  = (s0a < s1b) ? s0a : s1b;
   assign k2  = s1c;

   // Entry at logical index cursor sits in cell 0, so the next free entry
   // is at ring position count - cursor.
   assign live_lo = count_ff - cursor_ff;
   assign live_hi = DEPTH_CNT - cursor_ff;

   always_comb begin
      state_in      = state_ff;
      count_in      = count_ff;
      cursor_in     = cursor_ff;
      ovf_in        = ovf_ff;
      key_in        = key_ff;
      corners_in    = corners_ff;
      ctrl          = '0;
      emit          = 1'b0;
      rsp_status_in = rsp_status_ff;
      rsp_a_in      = rsp_a_ff;
      rsp_b_in      = rsp_b_ff;
      rsp_c_in      = rsp_c_ff;
      rsp_ovf_in    = rsp_ovf_ff;

      case (state_ff)
         S_IDLE: begin
            if (req_xfer) begin
               key_in     = {k0, k1, k2};
               corners_in = {ca, cb, cc};
               if (req_mode == MODE_INSERT) begin
                  state_in = S_LOOKUP;
               end else if (req_mode == MODE_CLEAR) begin
                  state_in = S_CLEAR;
               end else begin
                  state_in = S_DRAIN;
               end
            end
         end
         S_LOOKUP: begin
            state_in = S_RESOLVE;
         end
         S_RESOLVE: begin
            if (out_free) begin
               emit     = 1'b1;
               rsp_a_in = '0;
               rsp_b_in = '0;
               rsp_c_in = '0;
               state_in = S_IDLE;
               if (any_hit) begin
                  ctrl.mark     = 1'b1;
                  rsp_status_in = STAT_REPEAT;
               end else if (count_ff < DEPTH_CNT) begin
                  ctrl.write    = 1'b1;
                  count_in      = count_ff + 1'b1;
                  rsp_status_in = STAT_NEW;
               end else begin
                  ovf_in        = 1'b1;
                  rsp_status_in = STAT_FULL;
               end
               rsp_ovf_in = any_hit ? ovf_ff : ((count_ff < DEPTH_CNT) ? ovf_ff : 1'b1);
            end
         end
         S_DRAIN: begin
            if (cursor_ff >= count_ff) begin
               if (out_free) begin
                  emit          = 1'b1;
                  rsp_status_in = STAT_DONE;
                  rsp_a_in      = '0;
                  rsp_b_in      = '0;
                  rsp_c_in      = '0;
                  rsp_ovf_in    = ovf_ff;
                  state_in      = S_IDLE;
               end
            end else if (head_shared) begin
               ctrl.rotate = 1'b1;
               cursor_in   = cursor_ff + 1'b1;
            end else if (out_free) begin
               ctrl.rotate   = 1'b1;
               cursor_in     = cursor_ff + 1'b1;
               emit          = 1'b1;
               rsp_status_in = STAT_SURFACE;
               rsp_a_in      = PORT_BITS'(head_corners[3*CW-1 -: CW]);
               rsp_b_in      = PORT_BITS'(head_corners[2*CW-1 -: CW]);
               rsp_c_in      = PORT_BITS'(head_corners[CW-1:0]);
               rsp_ovf_in    = ovf_ff;
               state_in      = S_IDLE;
            end
         end
         S_CLEAR: begin
            if (out_free) begin
               emit          = 1'b1;
               count_in      = '0;
               cursor_in     = '0;
               ovf_in        = 1'b0;
               rsp_status_in = STAT_CLEARED;
               rsp_a_in      = '0;
               rsp_b_in      = '0;
               rsp_c_in      = '0;
               rsp_ovf_in    = 1'b0;
               state_in      = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      if (emit) begin
         rsp_valid_in = 1'b1;
      end
   end

   ste_ring #(
      .TABLE_DEPTH (TABLE_DEPTH),
      .INDEX_BITS  (INDEX_BITS)
   ) u_ring (
      .clock        (clock),
      .reset        (reset),
      .ctrl         (ctrl),
      .wr_pos       (PW'(live_lo)),
      .live_lo      (live_lo),
      .live_hi      (live_hi),
      .key_in       (key_ff),
      .corners_in   (corners_ff),
      .head_corners (head_corners),
      .head_shared  (head_shared),
      .any_hit      (any_hit)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         count_ff     <= '0;
         cursor_ff    <= '0;
         ovf_ff       <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         cursor_ff    <= cursor_in;
         ovf_ff       <= ovf_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      key_ff        <= key_in;
      corners_ff    <= corners_in;
      rsp_status_ff <= rsp_status_in;
      rsp_a_ff      <= rsp_a_in;
      rsp_b_ff      <= rsp_b_in;
      rsp_c_ff      <= rsp_c_in;
      rsp_ovf_ff    <= rsp_ovf_in;
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_status     = rsp_status_ff;
   assign rsp_out_a      = rsp_a_ff;
   assign rsp_out_b      = rsp_b_ff;
   assign rsp_out_c      = rsp_c_ff;
   assign rsp_overflowed = rsp_ovf_ff;

`ifndef SYNTHESIS
   // The drain cursor never passes the number of stored faces.
   a_cursor_bound: assert property (@(posedge clock) disable iff (reset)
      cursor_ff <= count_ff)
      else $error("drain cursor beyond stored faces");

   // A stored face is always reported as new.
   a_count_new: assert property (@(posedge clock) disable iff (reset)
      (count_ff != $past(count_ff) && count_ff != '0) |->
         (rsp_valid_ff && rsp_status_ff == STAT_NEW))
      else $error("face stored without a new-face transfer");

   // A surface face is only produced by a drain step.
   a_surface_src: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && !$past(rsp_valid_ff && rsp_stall) &&
       rsp_status_ff == STAT_SURFACE) |-> ($past(state_ff) == S_DRAIN))
      else $error("surface face outside a drain");

   // A dropped face always reports the sticky overflow.
   a_full_flag: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_status_ff == STAT_FULL) |-> (rsp_ovf_ff && ovf_ff))
      else $error("dropped face without overflow");
`endif

endmodule

@@ bench/surface_triangle_extractor_tb.sv @@
`timescale 1ns / 100ps
// ============================================================================
// surface_triangle_extractor_tb
// Self-checking bench for the surface triangle extractor. A short table of
// directed requests covers empty drains, extreme corners, repeats under
// several corner orders, skipping of shared faces, inserts during a drain,
// the aliased drain mode and clears. A fill pass then drives the face table
// past full. Random mesh-like sets of faces follow, with repeats in permuted
// corner order and interleaved drains and clears. Every response is checked
// against a behavioral model of the face table, or against the typed answer
// of a directed row, under varying idle and stall patterns on both channels.
// ============================================================================
module surface_triangle_extractor_tb;
   import ste_pkg::*;

   localparam int FACE_SLOTS    = TABLE_DEPTH_DEF;
   localparam int ITEM_TARGET   = 1275;
   localparam int CYCLE_LIMIT   = 500000;
   localparam int SETTLE_CYCLES = TABLE_DEPTH_DEF + 16;
   localparam int LONG_HOLD     = 80;
   localparam int POOL_MAX      = 24;
   localparam int DIRECTED_ROWS = 22;

   // Mode 3 has both bits set and decodes as a drain.
   localparam logic [MODE_BITS-1:0] MODE_DRAIN_ALIAS = 2'd3;
   localparam logic [PORT_BITS-1:0] CORNER_MASK      = PORT_BITS'((1 << INDEX_BITS_DEF) - 1);

   typedef struct packed {
      logic [STATUS_BITS-1:0] status;
      logic [PORT_BITS-1:0]   corner_a;
      logic [PORT_BITS-1:0]   corner_b;
      logic [PORT_BITS-1:0]   corner_c;
      logic                   overflowed;
   } face_answer_type;

   typedef struct {
      logic [MODE_BITS-1:0] mode;
      logic [PORT_BITS-1:0] a;
      logic [PORT_BITS-1:0] b;
      logic [PORT_BITS-1:0] c;
      bit                   typed;
      face_answer_type      want;
   } stim_row_type;

   logic                   clock = 1'b0;
   logic                   reset = 1'b1;
   logic                   req_valid = 1'b0;
   logic                   req_stall;
   logic [MODE_BITS-1:0]   req_mode = MODE_INSERT;
   logic [PORT_BITS-1:0]   req_corner_a = '0;
   logic [PORT_BITS-1:0]   req_corner_b = '0;
   logic [PORT_BITS-1:0]   req_corner_c = '0;
   logic                   rsp_valid;
   logic                   rsp_stall = 1'b0;
   logic [STATUS_BITS-1:0] rsp_status;
   logic [PORT_BITS-1:0]   rsp_out_a;
   logic [PORT_BITS-1:0]   rsp_out_b;
   logic [PORT_BITS-1:0]   rsp_out_c;
   logic                   rsp_overflowed;

   // Model of the face table.
   logic [3*PORT_BITS-1:0] stored_key [FACE_SLOTS];
   logic [3*PORT_BITS-1:0] stored_corners [FACE_SLOTS];
   bit                     stored_shared [FACE_SLOTS];
   int unsigned            stored_faces = 0;
   int unsigned            drain_pos = 0;
   bit                     overflow_seen = 1'b0;

   face_answer_type        expected_answers [$];
   stim_row_type           directed_rows [DIRECTED_ROWS];
   int unsigned            mismatches = 0;
   int unsigned            cycle_count = 0;
   int unsigned            items_sent = 0;
   int                     send_idle_pct = 0;
   int                     stall_pct = 0;
   bit                     hold_request = 1'b0;
   int                     hold_left = 0;

   surface_triangle_extractor dut (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_stall      (req_stall),
      .req_mode       (req_mode),
      .req_corner_a   (req_corner_a),
      .req_corner_b   (req_corner_b),
      .req_corner_c   (req_corner_c),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_status     (rsp_status),
      .rsp_out_a      (rsp_out_a),
      .rsp_out_b      (rsp_out_b),
      .rsp_out_c      (rsp_out_c),
      .rsp_overflowed (rsp_overflowed)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("tb: failure");
         $finish;
      end
   end

   // Applies one request to the model and returns the answer it should get.
   function automatic face_answer_type predict_face_answer(logic [MODE_BITS-1:0] mode,
                                                           logic [PORT_BITS-1:0] a,
                                                           logic [PORT_BITS-1:0] b,
                                                           logic [PORT_BITS-1:0] c);
      face_answer_type        ans;
      logic [PORT_BITS-1:0]   hi, mid, lo, t;
      logic [3*PORT_BITS-1:0] key;
      bit                     found;
      ans = '0;
      if (mode == MODE_INSERT) begin
         a &= CORNER_MASK;
         b &= CORNER_MASK;
         c &= CORNER_MASK;
         hi = a;
         mid = b;
         lo = c;
         if (hi < mid) begin t = hi; hi = mid; mid = t; end
         if (mid < lo) begin t = mid; mid = lo; lo = t; end
         if (hi < mid) begin t = hi; hi = mid; mid = t; end
         key = {hi, mid, lo};
         found = 1'b0;
         for (int i = 0; i < stored_faces; i++) begin
            if (!found && stored_key[i] == key) begin
               stored_shared[i] = 1'b1;
               found = 1'b1;
            end
         end
         if (found) begin
            ans.status = STAT_REPEAT;
         end else if (stored_faces >= FACE_SLOTS) begin
            overflow_seen = 1'b1;
            ans.status = STAT_FULL;
         end else begin
            stored_key[stored_faces] = key;
            stored_corners[stored_faces] = {a, b, c};
            stored_shared[stored_faces] = 1'b0;
            stored_faces++;
            ans.status = STAT_NEW;
         end
      end else if (mode == MODE_CLEAR) begin
         stored_faces = 0;
         drain_pos = 0;
         overflow_seen = 1'b0;
         ans.status = STAT_CLEARED;
      end else begin
         ans.status = STAT_DONE;
         while (drain_pos < stored_faces && ans.status == STAT_DONE) begin
            if (!stored_shared[drain_pos]) begin
               ans.status = STAT_SURFACE;
               {ans.corner_a, ans.corner_b, ans.corner_c} = stored_corners[drain_pos];
            end
            drain_pos++;
         end
      end
      ans.overflowed = overflow_seen;
      return ans;
   endfunction

   function automatic logic [PORT_BITS-1:0] random_corner();
      case ($urandom_range(7))
         0: return '0;
         1: return '1;
         2: return PORT_BITS'($urandom_range(15));
         default: return PORT_BITS'($urandom);
      endcase
   endfunction

   // One of the six corner orders of the same triangle.
   function automatic logic [3*PORT_BITS-1:0] permuted(logic [PORT_BITS-1:0] a,
                                                       logic [PORT_BITS-1:0] b,
                                                       logic [PORT_BITS-1:0] c);
      case ($urandom_range(5))
         0: return {a, b, c};
         1: return {b, c, a};
         2: return {c, a, b};
         3: return {a, c, b};
         4: return {b, a, c};
         default: return {c, b, a};
      endcase
   endfunction

   function automatic logic [MODE_BITS-1:0] random_drain_mode();
      return ($urandom_range(3) == 0) ? MODE_DRAIN_ALIAS : MODE_DRAIN;
   endfunction

   task automatic report_mismatch(string field, int unsigned got, int unsigned want);
      $display("mismatch at cycle %0d: %s is %0h, expected %0h", cycle_count, field, got, want);
      mismatches++;
   endtask

   // Called at a falling edge; returns at the falling edge after the transfer.
   task automatic send_request(logic [MODE_BITS-1:0] mode, logic [PORT_BITS-1:0] a,
                               logic [PORT_BITS-1:0] b, logic [PORT_BITS-1:0] c,
                               bit typed, face_answer_type typed_want);
      face_answer_type predicted;
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid <= 1'b1;
      req_mode <= mode;
      req_corner_a <= a;
      req_corner_b <= b;
      req_corner_c <= c;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      predicted = predict_face_answer(mode, a, b, c);
      expected_answers.insert(expected_answers.size(), typed ? typed_want : predicted);
      items_sent++;
      @(negedge clock);
   endtask

   task automatic wait_until_drained();
      req_valid <= 1'b0;
      do @(negedge clock); while (expected_answers.size() != 0);
   endtask

   always @(negedge clock) begin
      if (hold_request) begin
         hold_left = LONG_HOLD;
         hold_request = 1'b0;
      end
      if (hold_left > 0) begin
         hold_left--;
         rsp_stall <= 1'b1;
      end else begin
         rsp_stall <= ($urandom_range(99) < stall_pct);
      end
   end

   always @(posedge clock) begin
      face_answer_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (expected_answers.size() == 0) begin
            report_mismatch("status of unexpected response", 32'(rsp_status), 32'd0);
         end else begin
            want = expected_answers.pop_front();
            if (rsp_status !== want.status)
               report_mismatch("status", 32'(rsp_status), 32'(want.status));
            if (rsp_out_a !== want.corner_a)
               report_mismatch("out_a", 32'(rsp_out_a), 32'(want.corner_a));
            if (rsp_out_b !== want.corner_b)
               report_mismatch("out_b", 32'(rsp_out_b), 32'(want.corner_b));
            if (rsp_out_c !== want.corner_c)
               report_mismatch("out_c", 32'(rsp_out_c), 32'(want.corner_c));
            if (rsp_overflowed !== want.overflowed)
               report_mismatch("overflowed", 32'(rsp_overflowed), 32'(want.overflowed));
         end
      end
   end

   initial begin
      logic [PORT_BITS-1:0]   pool_a [POOL_MAX];
      logic [PORT_BITS-1:0]   pool_b [POOL_MAX];
      logic [PORT_BITS-1:0]   pool_c [POOL_MAX];
      logic [3*PORT_BITS-1:0] tri_corners;
      int                     pool_size;
      int                     episode;
      int                     pick;
      int                     roll;

      // Typed rows hold answers that follow directly from a fresh table.
      directed_rows = '{
         '{MODE_DRAIN,  16'h0000, 16'h0000, 16'h0000, 1'b1,
           '{STAT_DONE, 16'h0000, 16'h0000, 16'h0000, 1'b0}},
         '{MODE_INSERT, 16'h0000, 16'h0000, 16'h0000, 1'b1,
           '{STAT_NEW, 16'h0000, 16'h0000, 16'h0000, 1'b0}},
         '{MODE_INSERT, 16'hFFFF, 16'hFFFF, 16'hFFFF, 1'b1,
           '{STAT_NEW, 16'h0000, 16'h0000, 16'h0000, 1'b0}},
         '{MODE_INSERT, 16'h0001, 16'h0002, 16'h0003, 1'b0, '0},
         '{MODE_INSERT, 16'h0003, 16'h0001, 16'h0002, 1'b1,
           '{STAT_REPEAT, 16'h0000, 16'h0000, 16'h0000, 1'b0}},
         '{MODE_INSERT, 16'hFFFF, 16'h0000, 16'h8000, 1'b0, '0},
         '{MODE_INSERT, 16'h8000, 16'hFFFF, 16'h0000, 1'b1,
           '{STAT_REPEAT, 16'h0000, 16'h0000, 16'h0000, 1'b0}},
         '{MODE_INSERT, 16'h0005, 16'hAAAA, 16'h5555, 1'b0, '0},
         '{MODE_INSERT, 16'h0002, 16'h0003, 16'h0001, 1'b0, '0},
         '{MODE_DRAIN,  16'h1111, 16'h2222, 16'h3333, 1'b1,
           '{STAT_SURFACE, 16'h0000, 16'h0000, 16'h0000, 1'b0}},
         '{MODE_DRAIN,  16'h0000, 16'h0000, 16'h0000, 1'b1,
           '{STAT_SURFACE, 16'hFFFF, 16'hFFFF, 16'hFFFF, 1'b0}},
         '{MODE_DRAIN,  16'h0000, 16'h0000, 16'h0000, 1'b0, '0},
         '{MODE_INSERT, 16'h0007, 16'h0009, 16'h0007, 1'b0, '0},
         '{MODE_DRAIN,  16'h0000, 16'h0000, 16'h0000, 1'b0, '0},
         '{MODE_DRAIN,  16'h0000, 16'h0000, 16'h0000, 1'b1,
           '{STAT_DONE, 16'h0000, 16'h0000, 16'h0000, 1'b0}},
         '{MODE_DRAIN_ALIAS, 16'hFFFF, 16'hFFFF, 16'hFFFF, 1'b1,
           '{STAT_DONE, 16'h0000, 16'h0000, 16'h0000, 1'b0}},
         '{MODE_INSERT, 16'h0009, 16'h0007, 16'h0007, 1'b0, '0},
         '{MODE_CLEAR,  16'hFFFF, 16'h1234, 16'hFFFF, 1'b1,
           '{STAT_CLEARED, 16'h0000, 16'h0000, 16'h0000, 1'b0}},
         '{MODE_DRAIN_ALIAS, 16'h0000, 16'h0000, 16'h0000, 1'b1,
           '{STAT_DONE, 16'h0000, 16'h0000, 16'h0000, 1'b0}},
         '{MODE_INSERT, 16'h1234, 16'h00FF, 16'hFF00, 1'b1,
           '{STAT_NEW, 16'h0000, 16'h0000, 16'h0000, 1'b0}},
         '{MODE_DRAIN_ALIAS, 16'h0000, 16'h0000, 16'h0000, 1'b1,
           '{STAT_SURFACE, 16'h1234, 16'h00FF, 16'hFF00, 1'b0}},
         '{MODE_CLEAR,  16'h0000, 16'h0000, 16'h0000, 1'b1,
           '{STAT_CLEARED, 16'h0000, 16'h0000, 16'h0000, 1'b0}}
      };

      repeat (5) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      foreach (directed_rows[i])
         send_request(directed_rows[i].mode, directed_rows[i].a, directed_rows[i].b,
                      directed_rows[i].c, directed_rows[i].typed, directed_rows[i].want);

      // Fill the table past full while the receiver holds off, so the block
      // backs up into the request channel.
      wait_until_drained();
      hold_request = 1'b1;
      while (stored_faces < FACE_SLOTS)
         send_request(MODE_INSERT, random_corner(), PORT_BITS'($urandom),
                      PORT_BITS'($urandom), 1'b0, '0);
      send_idle_pct = 6;
      stall_pct = 6;
      repeat (12)
         send_request(MODE_INSERT, PORT_BITS'($urandom), PORT_BITS'($urandom),
                      PORT_BITS'($urandom), 1'b0, '0);
      repeat (24) begin
         tri_corners = stored_corners[$urandom_range(FACE_SLOTS - 1)];
         tri_corners = permuted(tri_corners[47:32], tri_corners[31:16], tri_corners[15:0]);
         send_request(MODE_INSERT, tri_corners[47:32], tri_corners[31:16],
                      tri_corners[15:0], 1'b0, '0);
      end
      repeat (FACE_SLOTS + 2)
         send_request(random_drain_mode(), PORT_BITS'($urandom), PORT_BITS'($urandom),
                      PORT_BITS'($urandom), 1'b0, '0);

      // Random mesh-like face sets, each opened by a clear.
      episode = 0;
      while (items_sent < ITEM_TARGET) begin
         case (episode % 4)
            0: begin send_idle_pct = 0;  stall_pct = 0;  end
            1: begin send_idle_pct = 69; stall_pct = 0;  end
            2: begin send_idle_pct = 0;  stall_pct = 69; end
            default: begin send_idle_pct = 6; stall_pct = 6; end
         endcase
         if ($urandom_range(7) == 0)
            wait_until_drained();
         if ($urandom_range(9) == 0)
            hold_request = 1'b1;
         pool_size = $urandom_range(1, POOL_MAX);
         for (int i = 0; i < pool_size; i++) begin
            pool_a[i] = random_corner();
            pool_b[i] = ($urandom_range(7) == 0) ? pool_a[i] : random_corner();
            pool_c[i] = random_corner();
         end
         send_request(MODE_CLEAR, PORT_BITS'($urandom), PORT_BITS'($urandom),
                      PORT_BITS'($urandom), 1'b0, '0);
         repeat ($urandom_range(1, 3 * pool_size)) begin
            roll = $urandom_range(99);
            pick = $urandom_range(pool_size - 1);
            tri_corners = permuted(pool_a[pick], pool_b[pick], pool_c[pick]);
            if (roll < 80)
               send_request(MODE_INSERT, tri_corners[47:32], tri_corners[31:16],
                            tri_corners[15:0], 1'b0, '0);
            else if (roll < 91)
               send_request(random_drain_mode(), PORT_BITS'($urandom),
                            PORT_BITS'($urandom), PORT_BITS'($urandom), 1'b0, '0);
            else if (roll < 94)
               send_request(MODE_CLEAR, '0, '0, '0, 1'b0, '0);
            else
               send_request(MODE_INSERT, PORT_BITS'($urandom), PORT_BITS'($urandom),
                            PORT_BITS'($urandom), 1'b0, '0);
         end
         repeat (pool_size + 2)
            send_request(random_drain_mode(), PORT_BITS'($urandom), PORT_BITS'($urandom),
                         PORT_BITS'($urandom), 1'b0, '0);
         episode++;
      end

      wait_until_drained();
      repeat (SETTLE_CYCLES) @(posedge clock);
      if (mismatches == 0 && expected_answers.size() == 0)
         $display("tb: success");
      else
         $display("tb: failure");
      $finish;
   end

endmodule

@@ surface_triangle_extractor.f @@
hw/rtl/ste_pkg.sv
hw/rtl/ste_cell.sv
hw/rtl/ste_ring.sv
hw/rtl/surface_triangle_extractor.sv
bench/surface_triangle_extractor_tb.sv
